@@ sv/mat_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mat_pkg: shared types and constants of the multi-alarm table
// Entry layout, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mat_pkg;

   localparam int MAX_ENTRIES  = 8;
   localparam int MAX_REPORTS  = 8;
   localparam int MIN_PER_HOUR = 60;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int REP_W = $clog2(MAX_REPORTS + 1);

   localparam int FUNC_W   = 3;
   localparam int ID_W     = 16;
   localparam int SLOT_W   = 3;
   localparam int HOUR_W   = 5;
   localparam int MIN_W    = 6;
   localparam int TOD_W    = 11;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 4;
   localparam int SEL_W    = 3;

   localparam int SLOT_CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   localparam logic [TOD_W-1:0] TICK_NONE = '1;

   localparam logic [FUNC_W-1:0] FN_ADD      = 3'd0;
   localparam logic [FUNC_W-1:0] FN_REMOVE   = 3'd1;
   localparam logic [FUNC_W-1:0] FN_UPDATE   = 3'd2;
   localparam logic [FUNC_W-1:0] FN_SET_EN   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_READ_IDX = 3'd4;
   localparam logic [FUNC_W-1:0] FN_READ_ID  = 3'd5;
   localparam logic [FUNC_W-1:0] FN_TICK     = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

   // Source of the entry fields of a result beat.
   localparam logic [SEL_W-1:0] SEL_NONE  = 3'd0;
   localparam logic [SEL_W-1:0] SEL_NEW   = 3'd1;
   localparam logic [SEL_W-1:0] SEL_STAGE = 3'd2;
   localparam logic [SEL_W-1:0] SEL_MOD   = 3'd3;
   localparam logic [SEL_W-1:0] SEL_PEND  = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic              rpt;
      logic              enabled;
      logic              vibrate;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic                load;
      logic                index_load;
      logic                scan_init;
      logic                shift_init;
      logic                scan_run;
      logic                shift_mode;
      logic                tick_init;
      logic                tick_fire;
      logic                add_commit;
      logic                modify_commit;
      logic                dec_count;
      logic                emit;
      logic [SEL_W-1:0]    emit_sel;
      logic [STATUS_W-1:0] emit_status;
      logic                emit_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              add_refused;
      logic              index_bad;
      logic              tick_repeat;
      logic              match;
      logic              fire;
      logic              scan_done;
      logic              pend_vld;
      logic              report_room;
   } dp_status_type;

   // Minute of day of an entry; no wrap, 31*60+63 still fits.
   function automatic logic [TOD_W-1:0] tod_of(input logic [HOUR_W-1:0] hour,
                                                input logic [MIN_W-1:0]  minute);
      tod_of = TOD_W'(hour) * TOD_W'(MIN_PER_HOUR) + TOD_W'(minute);
   endfunction

endpackage
`default_nettype wire

@@ sv/mat_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mat_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/mat_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mat_ctrl: operation sequencer of the multi-alarm table
// Decodes the latched request and steps the datapath through the table
// scan, the compaction after a remove and the result beats.
// ----------------------------------------------------------------------------
module mat_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mat_pkg::dp_status_type st,
   output mat_pkg::ctrl_cmd_type  cmd
);
   import mat_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (st.func)
               FN_ADD: begin
                  cmd.emit      = 1'b1;
                  cmd.emit_last = 1'b1;
                  if (st.add_refused) begin
                     cmd.emit_status = ST_FULL;
                     cmd.emit_sel    = SEL_NONE;
                  end else begin
                     cmd.add_commit  = 1'b1;
                     cmd.emit_status = ST_OK;
                     cmd.emit_sel    = SEL_NEW;
                  end
                  state_in = S_IDLE;
               end
               FN_REMOVE, FN_UPDATE, FN_SET_EN, FN_READ_ID: begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end
               FN_READ_IDX: begin
                  if (st.index_bad) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = ST_BAD_INDEX;
                     cmd.emit_sel    = SEL_NONE;
                     state_in        = S_IDLE;
                  end else begin
                     cmd.index_load = 1'b1;
                     state_in       = S_READ;
                  end
               end
               FN_TICK: begin
                  if (st.tick_repeat) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = ST_OK;
                     cmd.emit_sel    = SEL_NONE;
                     state_in        = S_IDLE;
                  end else begin
                     cmd.tick_init = 1'b1;
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               default: begin
                  cmd.emit        = 1'b1;
                  cmd.emit_last   = 1'b1;
                  cmd.emit_status = ST_OK;
                  cmd.emit_sel    = SEL_NONE;
                  state_in        = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (st.func == FN_TICK) begin
               if (st.fire) begin
                  // A new report pushes out the one held back, which is
                  // therefore not the final beat.
                  cmd.tick_fire = 1'b1;
                  if (st.report_room && st.pend_vld) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_OK;
                     cmd.emit_sel    = SEL_PEND;
                  end
               end else if (st.scan_done) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_last   = 1'b1;
                  cmd.emit_status = ST_OK;
                  cmd.emit_sel    = st.pend_vld ? SEL_PEND : SEL_NONE;
                  state_in        = S_IDLE;
               end
            end else if (st.match) begin
               cmd.scan_run    = 1'b0;
               cmd.emit        = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = ST_OK;
               state_in        = S_IDLE;
               case (st.func)
                  FN_REMOVE: begin
                     cmd.emit_sel   = SEL_STAGE;
                     cmd.dec_count  = 1'b1;
                     cmd.shift_init = 1'b1;
                     state_in       = S_SHIFT;
                  end
                  FN_UPDATE, FN_SET_EN: begin
                     cmd.modify_commit = 1'b1;
                     cmd.emit_sel      = SEL_MOD;
                  end
                  default: begin
                     cmd.emit_sel = SEL_STAGE;
                  end
               endcase
            end else if (st.scan_done) begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = ST_NOT_FOUND;
               cmd.emit_sel    = SEL_NONE;
               state_in        = S_IDLE;
            end
         end
         S_SHIFT: begin
            cmd.scan_run   = 1'b1;
            cmd.shift_mode = 1'b1;
            if (st.scan_done) begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            cmd.emit        = 1'b1;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = ST_OK;
            cmd.emit_sel    = SEL_STAGE;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

@@ sv/mat_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mat_dp: datapath of the multi-alarm table
// Holds the request, the table RAM with its scan pointer and compare stage,
// the counters and the registered result beat.
// ----------------------------------------------------------------------------
module mat_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  mat_pkg::ctrl_cmd_type           cmd,
   output mat_pkg::dp_status_type          st,
   input  logic [mat_pkg::FUNC_W-1:0]      req_func,
   input  logic [mat_pkg::ID_W-1:0]        req_alarm_id,
   input  logic [mat_pkg::SLOT_W-1:0]      req_slot_index,
   input  logic [mat_pkg::HOUR_W-1:0]      req_alarm_hour,
   input  logic [mat_pkg::MIN_W-1:0]       req_alarm_minute,
   input  logic                            req_repeat_daily,
   input  logic                            req_enable_bit,
   input  logic                            req_vibrate_bit,
   input  logic [mat_pkg::TOD_W-1:0]       req_current_minute,
   output logic                            rsp_strobe,
   output logic [mat_pkg::STATUS_W-1:0]    rsp_status,
   output logic [mat_pkg::ID_W-1:0]        rsp_entry_id,
   output logic [mat_pkg::HOUR_W-1:0]      rsp_entry_hour,
   output logic [mat_pkg::MIN_W-1:0]       rsp_entry_minute,
   output logic                            rsp_entry_repeat,
   output logic                            rsp_entry_enabled,
   output logic                            rsp_entry_vibrate,
   output logic [mat_pkg::USED_W-1:0]      rsp_entries_used,
   output logic                            rsp_fired,
   output logic                            rsp_buzz,
   output logic                            rsp_last
);
   import mat_pkg::*;

   // Latched request.
   logic [FUNC_W-1:0] func_ff;
   logic [ID_W-1:0]   id_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [HOUR_W-1:0] hour_ff;
   logic [MIN_W-1:0]  minute_ff;
   logic              rpt_ff;
   logic              en_ff;
   logic              vib_ff;
   logic [TOD_W-1:0]  now_ff;

   // Table state.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ID_W-1:0]  next_id_ff, next_id_in;
   logic [TOD_W-1:0] last_tick_ff, last_tick_in;

   // Scan pointer and compare stage.
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             stage_vld_ff, stage_vld_in;
   logic [IDX_W-1:0] stage_idx_ff, stage_idx_in;
   logic             issue;

   // Held-back tick report.
   logic             pend_vld_ff, pend_vld_in;
   entry_type        pend_ff, pend_in;
   logic [REP_W-1:0] reports_ff, reports_in;

   // Result beat.
   logic                rsp_strobe_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   entry_type           rsp_entry_ff, rsp_entry_in;
   logic [USED_W-1:0]   rsp_used_ff;
   logic                rsp_fired_ff, rsp_fired_in;
   logic                rsp_buzz_ff, rsp_buzz_in;
   logic                rsp_last_ff;

   // RAM ports.
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   entry_type          ram_wdata;
   logic [ENTRY_W-1:0] ram_rbits;
   entry_type          rd_entry;
   entry_type          new_entry;
   entry_type          mod_entry;
   entry_type          cleared_entry;

   mat_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ptr_ff[IDX_W-1:0]),
      .rd_data(ram_rbits)
   );

   assign rd_entry = entry_type'(ram_rbits);

   always_comb begin
      new_entry         = '0;
      new_entry.id      = next_id_ff;
      new_entry.hour    = hour_ff;
      new_entry.minute  = minute_ff;
      new_entry.rpt     = rpt_ff;
      new_entry.enabled = 1'b1;
      new_entry.vibrate = 1'b1;

      mod_entry         = rd_entry;
      mod_entry.enabled = en_ff;
      if (func_ff == FN_UPDATE) begin
         mod_entry.hour    = hour_ff;
         mod_entry.minute  = minute_ff;
         mod_entry.rpt     = rpt_ff;
         mod_entry.vibrate = vib_ff;
      end

      cleared_entry         = rd_entry;
      cleared_entry.enabled = 1'b0;
   end

   // During compaction the count is already one less, so the read runs up
   // to and including the old last position.
   assign issue = cmd.shift_mode ? (ptr_ff <= count_ff) : (ptr_ff < count_ff);

   always_comb begin
      st             = '0;
      st.func        = func_ff;
      st.add_refused = (count_ff >= CNT_W'(MAX_ENTRIES)) || (next_id_ff == '0);
      st.index_bad   = (SLOT_CMP_W'(slot_ff) >= SLOT_CMP_W'(count_ff));
      st.tick_repeat = (now_ff == last_tick_ff);
      st.match       = stage_vld_ff && (rd_entry.id == id_ff);
      st.fire        = stage_vld_ff && rd_entry.enabled &&
                       (tod_of(rd_entry.hour, rd_entry.minute) == now_ff);
      st.scan_done   = !stage_vld_ff && !issue;
      st.pend_vld    = pend_vld_ff;
      st.report_room = (reports_ff < REP_W'(MAX_REPORTS));
   end

   // Table write port: one writer per cycle by construction of the sequence.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = stage_idx_ff;
      ram_wdata = rd_entry;
      if (cmd.add_commit) begin
         ram_we    = 1'b1;
         ram_waddr = count_ff[IDX_W-1:0];
         ram_wdata = new_entry;
      end else if (cmd.modify_commit) begin
         ram_we    = 1'b1;
         ram_wdata = mod_entry;
      end else if (cmd.tick_fire && !rd_entry.rpt) begin
         ram_we    = 1'b1;
         ram_wdata = cleared_entry;
      end else if (cmd.shift_mode && stage_vld_ff) begin
         ram_we    = 1'b1;
         ram_waddr = stage_idx_ff - IDX_W'(1);
      end
   end

   always_comb begin
      count_in     = count_ff;
      next_id_in   = next_id_ff;
      last_tick_in = last_tick_ff;
      if (cmd.add_commit) begin
         count_in   = count_ff + CNT_W'(1);
         next_id_in = next_id_ff + ID_W'(1);
      end else if (cmd.dec_count) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.tick_init) begin
         last_tick_in = now_ff;
      end

      ptr_in       = ptr_ff;
      stage_vld_in = 1'b0;
      stage_idx_in = ptr_ff[IDX_W-1:0];
      if (cmd.scan_init) begin
         ptr_in = '0;
      end else if (cmd.shift_init) begin
         ptr_in = CNT_W'(stage_idx_ff) + CNT_W'(1);
      end else if (cmd.index_load) begin
         ptr_in = CNT_W'(slot_ff);
      end else if (cmd.scan_run && issue) begin
         ptr_in       = ptr_ff + CNT_W'(1);
         stage_vld_in = 1'b1;
      end

      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      reports_in  = reports_ff;
      if (cmd.tick_init) begin
         pend_vld_in = 1'b0;
         reports_in  = '0;
      end else if (cmd.tick_fire && st.report_room) begin
         pend_vld_in = 1'b1;
         pend_in     = rd_entry;
         reports_in  = reports_ff + REP_W'(1);
      end
   end

   always_comb begin
      case (cmd.emit_sel)
         SEL_NEW:   rsp_entry_in = new_entry;
         SEL_STAGE: rsp_entry_in = rd_entry;
         SEL_MOD:   rsp_entry_in = mod_entry;
         SEL_PEND:  rsp_entry_in = pend_ff;
         default:   rsp_entry_in = '0;
      endcase
      rsp_fired_in = (cmd.emit_sel == SEL_PEND);
      rsp_buzz_in  = (cmd.emit_sel == SEL_PEND) && pend_ff.vibrate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         next_id_ff    <= ID_W'(1);
         last_tick_ff  <= TICK_NONE;
         ptr_ff        <= '0;
         stage_vld_ff  <= 1'b0;
         pend_vld_ff   <= 1'b0;
         reports_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         next_id_ff    <= next_id_in;
         last_tick_ff  <= last_tick_in;
         ptr_ff        <= ptr_in;
         stage_vld_ff  <= stage_vld_in;
         pend_vld_ff   <= pend_vld_in;
         reports_ff    <= reports_in;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_func;
         id_ff     <= req_alarm_id;
         slot_ff   <= req_slot_index;
         hour_ff   <= req_alarm_hour;
         minute_ff <= req_alarm_minute;
         rpt_ff    <= req_repeat_daily;
         en_ff     <= req_enable_bit;
         vib_ff    <= req_vibrate_bit;
         now_ff    <= req_current_minute;
      end
      stage_idx_ff <= stage_idx_in;
      pend_ff      <= pend_in;
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_used_ff   <= USED_W'(count_in);
         rsp_fired_ff  <= rsp_fired_in;
         rsp_buzz_ff   <= rsp_buzz_in;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_id      = rsp_entry_ff.id;
   assign rsp_entry_hour    = rsp_entry_ff.hour;
   assign rsp_entry_minute  = rsp_entry_ff.minute;
   assign rsp_entry_repeat  = rsp_entry_ff.rpt;
   assign rsp_entry_enabled = rsp_entry_ff.enabled;
   assign rsp_entry_vibrate = rsp_entry_ff.vibrate;
   assign rsp_entries_used  = rsp_used_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_buzz          = rsp_buzz_ff;
   assign rsp_last          = rsp_last_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above table size");

   a_error_beat_empty : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && (rsp_status_ff != ST_OK) |->
         !rsp_fired_ff && !rsp_buzz_ff && (rsp_entry_ff == '0))
      else $error("error beat carries entry fields");

   a_fired_is_enabled : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_fired_ff |->
         rsp_entry_ff.enabled && (rsp_status_ff == ST_OK))
      else $error("fired beat reports a disabled entry");

   a_pend_counted : assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (reports_ff != '0))
      else $error("held report without a report count");

endmodule
`default_nettype wire

@@ sv/multi_alarm_table_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multi_alarm_table_unit: compacted table of alarm entries
// Add, remove, update, enable, read and minute-tick operations on a table
// of up to eight alarms, one command at a time.
// ----------------------------------------------------------------------------
// Usage:
// A command is taken at a rising edge with start high and busy low; its
// fields sit on the req_ ports. busy stays high until the command is done.
// Every command gives one result beat, except a tick on a new minute that
// matches several enabled entries: it gives one beat per fired entry in
// table order, rsp_last high on the final one. A beat is on the rsp_ ports
// for one cycle, marked by rsp_strobe, and the receiver cannot hold it off.
// For add, unused codes, a repeated tick and a bad index the decode state
// emits the beat; a read by index goes on to a read and a response state.
// Searches and ticks walk the table RAM one entry per cycle through its
// registered read port; the last beat comes at the latest once all
// entries in use are scanned. A remove then compacts the entries behind
// the removed one, one per cycle, before busy falls.
// Reset empties the table, sets the next id to one and forgets the last
// checked minute; the table RAM itself is not cleared.
// ----------------------------------------------------------------------------
module multi_alarm_table_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [mat_pkg::FUNC_W-1:0]      req_func,
   input  logic [mat_pkg::ID_W-1:0]        req_alarm_id,
   input  logic [mat_pkg::SLOT_W-1:0]      req_slot_index,
   input  logic [mat_pkg::HOUR_W-1:0]      req_alarm_hour,
   input  logic [mat_pkg::MIN_W-1:0]       req_alarm_minute,
   input  logic                            req_repeat_daily,
   input  logic                            req_enable_bit,
   input  logic                            req_vibrate_bit,
   input  logic [mat_pkg::TOD_W-1:0]       req_current_minute,
   output logic                            rsp_strobe,
   output logic [mat_pkg::STATUS_W-1:0]    rsp_status,
   output logic [mat_pkg::ID_W-1:0]        rsp_entry_id,
   output logic [mat_pkg::HOUR_W-1:0]      rsp_entry_hour,
   output logic [mat_pkg::MIN_W-1:0]       rsp_entry_minute,
   output logic                            rsp_entry_repeat,
   output logic                            rsp_entry_enabled,
   output logic                            rsp_entry_vibrate,
   output logic [mat_pkg::USED_W-1:0]      rsp_entries_used,
   output logic                            rsp_fired,
   output logic                            rsp_buzz,
   output logic                            rsp_last
);
   import mat_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type st;

   mat_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .st   (st),
      .cmd  (cmd)
   );

   mat_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_func          (req_func),
      .req_alarm_id      (req_alarm_id),
      .req_slot_index    (req_slot_index),
      .req_alarm_hour    (req_alarm_hour),
      .req_alarm_minute  (req_alarm_minute),
      .req_repeat_daily  (req_repeat_daily),
      .req_enable_bit    (req_enable_bit),
      .req_vibrate_bit   (req_vibrate_bit),
      .req_current_minute(req_current_minute),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_entry_id      (rsp_entry_id),
      .rsp_entry_hour    (rsp_entry_hour),
      .rsp_entry_minute  (rsp_entry_minute),
      .rsp_entry_repeat  (rsp_entry_repeat),
      .rsp_entry_enabled (rsp_entry_enabled),
      .rsp_entry_vibrate (rsp_entry_vibrate),
      .rsp_entries_used  (rsp_entries_used),
      .rsp_fired         (rsp_fired),
      .rsp_buzz          (rsp_buzz),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire
